FILE: hdl/daily_alarm_table_scheduler_core_defines.svh
// ---------------------------------------------------------------------------
// Daily alarm table scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler core.
// ---------------------------------------------------------------------------
`ifndef DAILY_ALARM_TABLE_SCHEDULER_CORE_DEFINES_SVH
`define DAILY_ALARM_TABLE_SCHEDULER_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define DATS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define DATS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/dats_pkg.sv
// ---------------------------------------------------------------------------
// Daily alarm table scheduler package
// Field widths, codes and shared types of the scheduler core.
// ---------------------------------------------------------------------------
package dats_pkg;

   // sizes and constants
   localparam int MAX_ENTRIES_DEF  = 8;
   localparam int SECONDS_PER_DAY  = 24 * 3600;
   localparam int MS_PER_SEC       = 1000;
   localparam int COOLDOWN_RESET   = 60;

   // field widths
   localparam int SEC_W       = 17;
   localparam int DAY_W       = 9;
   localparam int MS_W        = 32;
   localparam int DUR_W       = 16;
   localparam int COOLDOWN_W  = 16;
   localparam int COUNT_W     = 4;
   localparam int AIDX_W      = 3;
   localparam int EIDX_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 40;
   localparam int DIST_W      = 18;
   localparam int UNIT_W      = 32;

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_OVERRIDE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_SEC   = 2'd2;

   typedef enum logic [1:0] {
      KIND_FIRED   = 2'd0,
      KIND_SKIPPED = 2'd1,
      KIND_REPORT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_OVERRIDE = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_NONE     = 2'd3
   } status_type;

   // shared unit operations
   typedef enum logic {
      OP_GAP  = 1'b0,
      OP_DIST = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [UNIT_W-1:0]  a;
      logic [UNIT_W-1:0]  b;
      logic [UNIT_W-1:0]  c;
      logic [UNIT_W-1:0]  lim;
   } unit_req_type;

   typedef struct packed {
      logic [UNIT_W-1:0]  value;
      logic               below;
   } unit_rsp_type;

   // alarm table write data
   typedef struct packed {
      logic               load_entry;
      logic [SEC_W-1:0]   time_sec;
      logic [DUR_W-1:0]   dur;
      logic [DAY_W-1:0]   day;
   } tbl_wdata_type;

endpackage

FILE: hdl/daily_alarm_table_scheduler_core.sv
// ---------------------------------------------------------------------------
// Daily alarm table scheduler core
// Holds a table of daily alarms, fires matching entries on each tick under
// a global cooldown and reports the nearest upcoming alarm.
// ---------------------------------------------------------------------------
// A write command (req_tuser = 1) gives no result. A tick takes the request,
// runs a firing pass over N = min(entry_count, MAX_ENTRIES) entries, then a
// report pass over the same entries, and then loads the report; a tick under
// rules_override or with no entries goes straight to loading the report. Each
// entry step goes through the one shared add/compare unit, so every entry is
// visited twice per tick. A fired/skipped result or the report that waits on
// rsp_tready stalls the tick.
// The block is not ready for a new transaction until the report is loaded;
// the result register lets the next transaction enter while it waits.
// ---------------------------------------------------------------------------
`include "daily_alarm_table_scheduler_core_defines.svh"

module daily_alarm_table_scheduler_core #(
   parameter int MAX_ENTRIES = dats_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_sec, day_of_year, now_ms, entry_index, entry_time_sec,
   // entry_duration_sec, zero pad
   input  logic [dats_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic                                req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // alarm_index, duration_sec, report_status, next_in_sec, zero pad
   output logic [dats_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   // configuration
   input  logic                                csr_we,
   input  logic [dats_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dats_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   // request fields
   logic                              req_cmd;
   logic [dats_pkg::SEC_W-1:0]        req_now_sec;
   logic [dats_pkg::DAY_W-1:0]        req_day_of_year;
   logic [dats_pkg::MS_W-1:0]         req_now_ms;
   logic [dats_pkg::EIDX_W-1:0]       req_entry_index;
   logic [dats_pkg::SEC_W-1:0]        req_entry_time_sec;
   logic [dats_pkg::DUR_W-1:0]        req_entry_duration_sec;

   assign req_cmd                = req_tuser;
   assign req_now_sec            = req_tdata[16:0];
   assign req_day_of_year        = req_tdata[25:17];
   assign req_now_ms             = req_tdata[57:26];
   assign req_entry_index        = req_tdata[60:58];
   assign req_entry_time_sec     = req_tdata[77:61];
   assign req_entry_duration_sec = req_tdata[93:78];

   // configuration registers
   logic                                override_ff;
   logic [dats_pkg::COUNT_W-1:0]        entry_count_ff;
   logic [dats_pkg::COOLDOWN_W-1:0]     cooldown_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         override_ff    <= 1'b0;
         entry_count_ff <= '0;
         cooldown_ff    <= dats_pkg::COOLDOWN_W'(dats_pkg::COOLDOWN_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            dats_pkg::CSR_RULES_OVERRIDE: override_ff    <= csr_wdata[0];
            dats_pkg::CSR_ENTRY_COUNT:    entry_count_ff <= csr_wdata[dats_pkg::COUNT_W-1:0];
            dats_pkg::CSR_COOLDOWN_SEC:   cooldown_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer registers
   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 idx_ff, idx_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [dats_pkg::SEC_W-1:0]       now_sec_ff, now_sec_in;
   logic [dats_pkg::DAY_W-1:0]       day_ff, day_in;
   logic [dats_pkg::MS_W-1:0]        now_ms_ff, now_ms_in;
   logic [dats_pkg::MS_W-1:0]        need_ff, need_in;
   logic [dats_pkg::MS_W-1:0]        last_ms_ff, last_ms_in;
   logic [dats_pkg::DIST_W-1:0]      best_ff, best_in;
   logic [dats_pkg::DUR_W-1:0]       best_dur_ff, best_dur_in;
   dats_pkg::status_type             tick_status_ff, tick_status_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   dats_pkg::kind_type               rsp_kind_ff, rsp_kind_in;
   logic [dats_pkg::AIDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [dats_pkg::DUR_W-1:0]       rsp_dur_ff, rsp_dur_in;
   dats_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [dats_pkg::SEC_W-1:0]       rsp_next_ff, rsp_next_in;
   logic                             rsp_last_ff, rsp_last_in;

   // table and unit connections
   logic                             tbl_we;
   logic [IDX_W-1:0]                 tbl_waddr;
   dats_pkg::tbl_wdata_type          tbl_wdata;
   logic [dats_pkg::SEC_W-1:0]       rd_time;
   logic [dats_pkg::DUR_W-1:0]       rd_dur;
   logic [dats_pkg::DAY_W-1:0]       rd_day;
   dats_pkg::unit_req_type           unit_req;
   dats_pkg::unit_rsp_type           unit_rsp;

   logic                             out_free;
   logic                             last_idx;
   logic                             match;
   logic                             fire_go;
   logic [CNT_W-1:0]                 count_clamp;

   dats_table #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_time (rd_time),
      .rd_dur  (rd_dur),
      .rd_day  (rd_day)
   );

   dats_unit u_unit (
      .req (unit_req),
      .rsp (unit_rsp)
   );

   // entries in use, capped at the table size
   always_comb begin
      if (32'(entry_count_ff) > 32'(MAX_ENTRIES)) begin
         count_clamp = CNT_W'(MAX_ENTRIES);
      end else begin
         count_clamp = CNT_W'(entry_count_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = (idx_ff == count_ff - CNT_W'(1));
   assign match      = (rd_time == now_sec_ff) && (rd_day != day_ff);

   // shared unit operands: cooldown gap while firing, distance while scanning
   always_comb begin
      if (state_ff == ST_SCAN) begin
         unit_req.op  = dats_pkg::OP_DIST;
         unit_req.a   = 32'(rd_time);
         unit_req.b   = (rd_time > now_sec_ff) ? '0 : 32'(dats_pkg::SECONDS_PER_DAY);
         unit_req.c   = 32'(now_sec_ff);
         unit_req.lim = 32'(best_ff);
      end else begin
         unit_req.op  = dats_pkg::OP_GAP;
         unit_req.a   = now_ms_ff;
         unit_req.b   = '0;
         unit_req.c   = last_ms_ff;
         unit_req.lim = need_ff;
      end
   end

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      now_sec_in     = now_sec_ff;
      day_in         = day_ff;
      now_ms_in      = now_ms_ff;
      need_in        = need_ff;
      last_ms_in     = last_ms_ff;
      best_in        = best_ff;
      best_dur_in    = best_dur_ff;
      tick_status_in = tick_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_dur_in     = rsp_dur_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_last_in    = rsp_last_ff;
      tbl_we         = 1'b0;
      tbl_waddr      = idx_ff[IDX_W-1:0];
      tbl_wdata      = '0;
      fire_go        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_cmd == dats_pkg::CMD_WRITE) begin
                  // entry load, clears the fired day
                  if (32'(req_entry_index) < 32'(MAX_ENTRIES)) begin
                     tbl_we               = 1'b1;
                     tbl_waddr            = IDX_W'(req_entry_index);
                     tbl_wdata.load_entry = 1'b1;
                     tbl_wdata.time_sec   = req_entry_time_sec;
                     tbl_wdata.dur        = req_entry_duration_sec;
                  end
               end else begin
                  // tick: latch the transaction and start the passes
                  idx_in      = '0;
                  count_in    = count_clamp;
                  now_sec_in  = req_now_sec;
                  day_in      = req_day_of_year;
                  now_ms_in   = req_now_ms;
                  need_in     = 32'(cooldown_ff) * 32'(dats_pkg::MS_PER_SEC);
                  best_in     = dats_pkg::DIST_W'(dats_pkg::SECONDS_PER_DAY + 1);
                  best_dur_in = '0;
                  if (override_ff) begin
                     tick_status_in = dats_pkg::STATUS_OVERRIDE;
                     state_in       = ST_REPORT;
                  end else if (count_clamp == '0) begin
                     tick_status_in = dats_pkg::STATUS_EMPTY;
                     state_in       = ST_REPORT;
                  end else begin
                     tick_status_in = dats_pkg::STATUS_FOUND;
                     state_in       = ST_FIRE;
                  end
               end
            end
         end

         ST_FIRE: begin
            if (!match || out_free) begin
               if (match) begin
                  // fired or skipped result for this entry
                  rsp_valid_in  = 1'b1;
                  rsp_idx_in    = dats_pkg::AIDX_W'(idx_ff[IDX_W-1:0]);
                  rsp_dur_in    = rd_dur;
                  rsp_status_in = dats_pkg::STATUS_FOUND;
                  rsp_next_in   = '0;
                  rsp_last_in   = 1'b0;
                  if (last_ms_ff == '0 || !unit_rsp.below) begin
                     fire_go       = 1'b1;
                     rsp_kind_in   = dats_pkg::KIND_FIRED;
                     tbl_we        = 1'b1;
                     tbl_wdata.day = day_ff;
                     last_ms_in    = now_ms_ff;
                  end else begin
                     rsp_kind_in   = dats_pkg::KIND_SKIPPED;
                  end
               end
               if (last_idx) begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end

         ST_SCAN: begin
            // nearest upcoming alarm, first entry wins on ties
            if (!(rd_day == day_ff && rd_time == now_sec_ff) && unit_rsp.below) begin
               best_in     = unit_rsp.value[dats_pkg::DIST_W-1:0];
               best_dur_in = rd_dur;
            end
            if (last_idx) begin
               state_in = ST_REPORT;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dats_pkg::KIND_REPORT;
               rsp_idx_in   = '0;
               rsp_last_in  = 1'b1;
               if (tick_status_ff == dats_pkg::STATUS_FOUND &&
                   32'(best_ff) <= 32'(dats_pkg::SECONDS_PER_DAY)) begin
                  rsp_status_in = dats_pkg::STATUS_FOUND;
                  rsp_dur_in    = best_dur_ff;
                  rsp_next_in   = dats_pkg::SEC_W'(best_ff);
               end else begin
                  rsp_status_in = (tick_status_ff == dats_pkg::STATUS_FOUND) ?
                                  dats_pkg::STATUS_NONE : tick_status_ff;
                  rsp_dur_in    = '0;
                  rsp_next_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ms_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ms_ff   <= last_ms_in;
      end
      idx_ff         <= idx_in;
      count_ff       <= count_in;
      now_sec_ff     <= now_sec_in;
      day_ff         <= day_in;
      now_ms_ff      <= now_ms_in;
      need_ff        <= need_in;
      best_ff        <= best_in;
      best_dur_ff    <= best_dur_in;
      tick_status_ff <= tick_status_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_dur_ff     <= rsp_dur_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_next_ff, rsp_status_ff, rsp_dur_ff, rsp_idx_ff};

   // checks
   `DATS_ASSERT_SAME(a_last_on_report, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == dats_pkg::KIND_REPORT), "last flag does not match report result")
   `DATS_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == ST_FIRE || state_ff == ST_SCAN, idx_ff < count_ff, "entry scan index beyond entries in use")
   `DATS_ASSERT_NEXT(a_stamp_on_fire, clock, reset, !fire_go, $stable(last_ms_ff), "fire timestamp changed without a firing")

endmodule

FILE: hdl/dats_unit.sv
// ---------------------------------------------------------------------------
// Daily alarm scheduler shared arithmetic unit
// Computes a + b - c and compares the result against a limit; used for
// the cooldown gap and for the distance to each alarm.
// ---------------------------------------------------------------------------
module dats_unit (
   input  dats_pkg::unit_req_type req,
   output dats_pkg::unit_rsp_type rsp
);

   logic [dats_pkg::UNIT_W+1:0] sum;
   logic [dats_pkg::UNIT_W-1:0] value;

   // three operand add with sign kept in the top bit
   assign sum = {2'b00, req.a} + {2'b00, req.b} - {2'b00, req.c};

   // distances clamp at zero, gaps wrap modulo 2^32
   always_comb begin
      if (req.op == dats_pkg::OP_DIST && sum[dats_pkg::UNIT_W+1]) begin
         value = '0;
      end else begin
         value = sum[dats_pkg::UNIT_W-1:0];
      end
   end

   assign rsp.value = value;
   assign rsp.below = (value < req.lim);

endmodule

FILE: hdl/dats_table.sv
// ---------------------------------------------------------------------------
// Daily alarm scheduler entry table
// Per-entry alarm time, duration and last fired day, one write port and
// one read port addressed by the sequencer.
// ---------------------------------------------------------------------------
module dats_table #(
   parameter int MAX_ENTRIES = dats_pkg::MAX_ENTRIES_DEF,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  dats_pkg::tbl_wdata_type      wr_data,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [dats_pkg::SEC_W-1:0]   rd_time,
   output logic [dats_pkg::DUR_W-1:0]   rd_dur,
   output logic [dats_pkg::DAY_W-1:0]   rd_day
);

   logic [dats_pkg::SEC_W-1:0] time_ff [MAX_ENTRIES];
   logic [dats_pkg::DUR_W-1:0] dur_ff  [MAX_ENTRIES];
   logic [dats_pkg::DAY_W-1:0] day_ff  [MAX_ENTRIES];

   // alarm time and duration, loaded by write commands only
   always_ff @(posedge clock) begin
      if (wr_en && wr_data.load_entry) begin
         time_ff[wr_addr] <= wr_data.time_sec;
         dur_ff[wr_addr]  <= wr_data.dur;
      end
   end

   // fired day, zero means never fired
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            day_ff[i] <= '0;
         end
      end else if (wr_en) begin
         day_ff[wr_addr] <= wr_data.day;
      end
   end

   // read port
   assign rd_time = time_ff[rd_addr];
   assign rd_dur  = dur_ff[rd_addr];
   assign rd_day  = day_ff[rd_addr];

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Daily alarm table scheduler testbench
// Drives entry writes and time ticks into the scheduler core over the request
// stream and tracks the alarm table, fired days and cooldown in a scoreboard.
// Every fired, skipped and report transaction on the result stream is checked
// field by field against the scoreboard's prediction. Register settings change
// between phases, while the core is idle. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dats_pkg::*;

   localparam int RUN_LIMIT_NS  = 4_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int POOL_SIZE     = 3;

   typedef enum {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_type;
   typedef enum {PRESS_NONE, PRESS_RX_HOLD, PRESS_DRAIN} pressure_type;

   typedef struct {
      logic                cmd;
      logic [SEC_W-1:0]    now_sec;
      logic [DAY_W-1:0]    day;
      logic [MS_W-1:0]     now_ms;
      logic [EIDX_W-1:0]   entry_index;
      logic [SEC_W-1:0]    entry_time;
      logic [DUR_W-1:0]    entry_dur;
   } alarm_request_type;

   typedef struct {
      kind_type            kind;
      logic [AIDX_W-1:0]   alarm_index;
      logic [DUR_W-1:0]    duration;
      status_type          status;
      logic [SEC_W-1:0]    next_in;
      logic                last;
   } alarm_result_type;

   // alarm table tracker: predicts the results of each accepted transaction
   class alarm_schedule_board;
      logic                override_on;
      logic [COUNT_W-1:0]  entry_count;
      logic [COOLDOWN_W-1:0] cooldown_sec;
      logic [SEC_W-1:0]    time_tbl [MAX_ENTRIES_DEF];
      logic [DUR_W-1:0]    dur_tbl [MAX_ENTRIES_DEF];
      logic [DAY_W-1:0]    fired_day [MAX_ENTRIES_DEF];
      logic [MS_W-1:0]     last_fire_ms;
      alarm_result_type    due_results [$];
      int ticks, writes, firings, skips, reports, checked, mismatches;

      function new();
         override_on = 1'b0;
         entry_count = '0;
         cooldown_sec = COOLDOWN_W'(COOLDOWN_RESET);
         last_fire_ms = '0;
         foreach (fired_day[i]) begin
            time_tbl[i] = '0;
            dur_tbl[i] = '0;
            fired_day[i] = '0;
         end
         ticks = 0; writes = 0; firings = 0; skips = 0;
         reports = 0; checked = 0; mismatches = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_RULES_OVERRIDE: override_on = value[0];
            CSR_ENTRY_COUNT:    entry_count = value[COUNT_W-1:0];
            CSR_COOLDOWN_SEC:   cooldown_sec = value[COOLDOWN_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_result(kind_type kind, logic [AIDX_W-1:0] idx,
                                logic [DUR_W-1:0] dur, status_type status,
                                logic [SEC_W-1:0] next_in, logic last);
         alarm_result_type r;
         r.kind = kind;
         r.alarm_index = idx;
         r.duration = dur;
         r.status = status;
         r.next_in = next_in;
         r.last = last;
         due_results.push_back(r);
         case (kind)
            KIND_FIRED:   firings++;
            KIND_SKIPPED: skips++;
            default:      reports++;
         endcase
      endfunction

      function void note_request(alarm_request_type rq);
         int               in_use;
         logic [MS_W-1:0]  gap;
         logic [MS_W-1:0]  need;
         longint           span_sec;
         longint           best;
         logic [DUR_W-1:0] best_dur;
         // entry write: load the entry and forget its fired day
         if (rq.cmd == CMD_WRITE) begin
            writes++;
            time_tbl[rq.entry_index] = rq.entry_time;
            dur_tbl[rq.entry_index] = rq.entry_dur;
            fired_day[rq.entry_index] = '0;
            return;
         end
         ticks++;
         if (override_on) begin
            push_result(KIND_REPORT, '0, '0, STATUS_OVERRIDE, '0, 1'b1);
            return;
         end
         in_use = (entry_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(entry_count);
         need = cooldown_sec * MS_PER_SEC;
         // firing pass under the shared cooldown, zero meaning never fired
         for (int i = 0; i < in_use; i++) begin
            if (time_tbl[i] == rq.now_sec && fired_day[i] != rq.day) begin
               gap = rq.now_ms - last_fire_ms;
               if (last_fire_ms == '0 || gap >= need) begin
                  fired_day[i] = rq.day;
                  last_fire_ms = rq.now_ms;
                  push_result(KIND_FIRED, AIDX_W'(i), dur_tbl[i], STATUS_FOUND, '0, 1'b0);
               end else begin
                  push_result(KIND_SKIPPED, AIDX_W'(i), dur_tbl[i], STATUS_FOUND, '0, 1'b0);
               end
            end
         end
         if (in_use == 0) begin
            push_result(KIND_REPORT, '0, '0, STATUS_EMPTY, '0, 1'b1);
            return;
         end
         // nearest upcoming entry, first index wins a tie
         best = longint'(SECONDS_PER_DAY) + 1;
         best_dur = '0;
         for (int i = 0; i < in_use; i++) begin
            if (fired_day[i] == rq.day && time_tbl[i] == rq.now_sec) continue;
            if (time_tbl[i] > rq.now_sec)
               span_sec = longint'(time_tbl[i]) - longint'(rq.now_sec);
            else
               span_sec = longint'(SECONDS_PER_DAY) - longint'(rq.now_sec)
                          + longint'(time_tbl[i]);
            if (span_sec < 0) span_sec = 0;
            if (span_sec < best) begin
               best = span_sec;
               best_dur = dur_tbl[i];
            end
         end
         if (best <= longint'(SECONDS_PER_DAY))
            push_result(KIND_REPORT, '0, best_dur, STATUS_FOUND, SEC_W'(best), 1'b1);
         else
            push_result(KIND_REPORT, '0, '0, STATUS_NONE, '0, 1'b1);
      endfunction

      function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
         if (expected !== actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [RSP_DATA_W-1:0] data, logic last);
         alarm_result_type want;
         checked++;
         if (due_results.size() == 0) begin
            $error("result transaction of kind %0d arrived with nothing expected", kind);
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         // tdata: alarm_index, duration_sec, report_status, next_in_sec from bit 0 up
         compare_field("kind", 32'(want.kind), 32'(kind));
         compare_field("alarm_index", 32'(want.alarm_index), 32'(data[2:0]));
         compare_field("duration_sec", 32'(want.duration), 32'(data[18:3]));
         compare_field("report_status", 32'(want.status), 32'(data[20:19]));
         compare_field("next_in_sec", 32'(want.next_in), 32'(data[37:21]));
         compare_field("last", 32'(want.last), 32'(last));
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // now_sec, day_of_year, now_ms, entry_index, entry_time_sec,
   // entry_duration_sec, zero pad
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // cmd
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // alarm_index, duration_sec, report_status, next_in_sec, zero pad
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   // kind
   logic [1:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   alarm_schedule_board     board;
   int                      burst_left;
   int                      settings_applied;
   logic [MS_W-1:0]         clock_ms;
   logic [DAY_W-1:0]        today;
   logic [SEC_W-1:0]        time_pool [POOL_SIZE];
   logic                    hold_request = 1'b0;

   daily_alarm_table_scheduler_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin : receiver
      rx_mode_type mode;
      int          stretch_left;
      mode = RX_STEADY;
      stretch_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (stretch_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 2));
            stretch_left = $urandom_range(4, 40);
         end
         stretch_left--;
         case (mode)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic alarm_request_type tick_request(int sec, int day, int ms);
      alarm_request_type rq;
      rq.cmd = CMD_TICK;
      rq.now_sec = SEC_W'(sec);
      rq.day = DAY_W'(day);
      rq.now_ms = MS_W'(ms);
      rq.entry_index = '0;
      rq.entry_time = '0;
      rq.entry_dur = '0;
      return rq;
   endfunction

   function automatic alarm_request_type entry_write(int idx, int t, int dur);
      alarm_request_type rq;
      rq = tick_request(0, 0, 0);
      rq.cmd = CMD_WRITE;
      rq.entry_index = EIDX_W'(idx);
      rq.entry_time = SEC_W'(t);
      rq.entry_dur = DUR_W'(dur);
      return rq;
   endfunction

   // mostly ticks that land on entry times, some writes, some noise
   function automatic alarm_request_type random_request();
      alarm_request_type rq;
      int                roll;
      int                in_use;
      rq.cmd = CMD_TICK;
      rq.now_sec = SEC_W'($urandom_range(0, 131071));
      rq.day = DAY_W'($urandom_range(0, 511));
      rq.now_ms = $urandom();
      rq.entry_index = EIDX_W'($urandom_range(0, 7));
      rq.entry_time = SEC_W'($urandom_range(0, 131071));
      rq.entry_dur = DUR_W'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      in_use = (board.entry_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF
                                                     : int'(board.entry_count);
      if (roll < 12) begin
         rq.cmd = CMD_WRITE;
         if ($urandom_range(0, 4) != 0) rq.entry_time = time_pool[$urandom_range(0, POOL_SIZE-1)];
      end else if (roll < 90) begin
         if (roll < 80 && in_use > 0) begin
            rq.now_sec = board.time_tbl[$urandom_range(0, in_use-1)];
         end else begin
            case ($urandom_range(0, 2))
               0:       rq.now_sec = '0;
               1:       rq.now_sec = SEC_W'(SECONDS_PER_DAY - 1);
               default: rq.now_sec = SEC_W'($urandom_range(0, SECONDS_PER_DAY - 1));
            endcase
         end
         if ($urandom_range(0, 9) == 0) today = (today >= 366) ? 9'd1 : today + 9'd1;
         rq.day = today;
         case ($urandom_range(0, 3))
            0:       clock_ms += $urandom_range(0, 999);
            1:       clock_ms += $urandom_range(1000, 70000);
            2:       clock_ms += $urandom_range(50000, 200000);
            default: clock_ms += $urandom_range(0, 80_000_000);
         endcase
         rq.now_ms = clock_ms;
      end
      return rq;
   endfunction

   // offer one transaction, called at a falling edge, returns at a falling edge
   task automatic drive_request(input alarm_request_type rq);
      req_tvalid <= 1'b1;
      req_tuser <= rq.cmd;
      req_tdata <= {2'b00, rq.entry_dur, rq.entry_time, rq.entry_index,
                    rq.now_ms, rq.day, rq.now_sec};
      do @(posedge clock); while (!req_tready);
      board.note_request(rq);
      @(negedge clock);
   endtask

   // bursts of random length separated by random gaps
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
   endtask

   // stop offering, wait for every expected result, then let writes finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write all three registers on consecutive cycles
   task automatic apply_settings(input logic ovr, input logic [COUNT_W-1:0] cnt,
                                 input logic [COOLDOWN_W-1:0] cool);
      csr_we <= 1'b1;
      csr_index <= CSR_RULES_OVERRIDE;
      csr_wdata <= CSR_DATA_W'(ovr);
      @(negedge clock);
      csr_index <= CSR_ENTRY_COUNT;
      csr_wdata <= CSR_DATA_W'(cnt);
      @(negedge clock);
      csr_index <= CSR_COOLDOWN_SEC;
      csr_wdata <= CSR_DATA_W'(cool);
      @(negedge clock);
      csr_we <= 1'b0;
      board.write_register(CSR_RULES_OVERRIDE, CSR_DATA_W'(ovr));
      board.write_register(CSR_ENTRY_COUNT, CSR_DATA_W'(cnt));
      board.write_register(CSR_COOLDOWN_SEC, CSR_DATA_W'(cool));
      settings_applied++;
   endtask

   // one register setting: reload the table from a time pool, then random traffic
   task automatic run_phase(input logic ovr, input logic [COUNT_W-1:0] cnt,
                            input logic [COOLDOWN_W-1:0] cool, input int items,
                            input pressure_type pressure);
      settle();
      apply_settings(ovr, cnt, cool);
      foreach (time_pool[k]) time_pool[k] = SEC_W'($urandom_range(0, SECONDS_PER_DAY - 1));
      for (int n = 0; n < items; n++) begin
         if (n < MAX_ENTRIES_DEF)
            drive_request(entry_write(n, int'(time_pool[$urandom_range(0, POOL_SIZE-1)]),
                                      int'($urandom_range(0, 65535))));
         else
            drive_request(random_request());
         pace_sender();
         if (n == items / 2) begin
            if (pressure == PRESS_RX_HOLD) hold_request = 1'b1;
            if (pressure == PRESS_DRAIN) settle();
         end
      end
   endtask

   initial begin : stimulus
      board = new();
      burst_left = 0;
      settings_applied = 0;
      today = 9'd100;
      clock_ms = 32'hFFF0_0000;
      foreach (time_pool[k]) time_pool[k] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // no entries in use yet
      drive_request(tick_request(0, 1, 0));
      // load the table: shared times, day boundaries, an out-of-range time
      drive_request(entry_write(0, 100, 0));
      drive_request(entry_write(1, 100, 65535));
      drive_request(entry_write(2, SECONDS_PER_DAY - 1, 1));
      drive_request(entry_write(3, 0, 2));
      drive_request(entry_write(4, 131071, 3));
      drive_request(entry_write(5, 5000, 4));
      drive_request(entry_write(6, 100, 5));
      drive_request(entry_write(7, 200, 6));
      settle();
      apply_settings(1'b0, 4'd8, 16'd60);
      // day zero never fires a fresh entry
      drive_request(tick_request(100, 0, 0));
      // firing at millisecond zero still reads as never fired
      drive_request(tick_request(100, 1, 0));
      drive_request(tick_request(100, 1, 5));
      drive_request(tick_request(200, 1, 1000));
      // rewrite clears the fired day, then cooldown skip and exact threshold
      drive_request(entry_write(7, 200, 7));
      drive_request(tick_request(200, 1, 2000));
      drive_request(tick_request(200, 1, 61000));
      // millisecond counter wrap on either side of the threshold
      drive_request(tick_request(SECONDS_PER_DAY - 1, 366, 32'hFFFF_FFFF));
      drive_request(tick_request(0, 1, 59998));
      drive_request(tick_request(0, 1, 59999));
      // second of day beyond the day length
      drive_request(tick_request(131071, 511, 32'h8000_0000));
      drive_request(tick_request(100000, 2, 32'h8001_0000));
      settle();
      apply_settings(1'b1, 4'd8, 16'd60);
      drive_request(tick_request(100, 3, 32'h8002_0000));
      settle();
      // single entry fired today at now: nothing upcoming
      apply_settings(1'b0, 4'd1, 16'd0);
      drive_request(tick_request(100, 3, 32'h9000_0000));
      settle();
      // count above the table size, longest cooldown
      apply_settings(1'b0, 4'd15, 16'hFFFF);
      drive_request(tick_request(100, 4, 32'h9000_0002));

      run_phase(1'b0, 4'd8, 16'd60, 70, PRESS_RX_HOLD);
      run_phase(1'b0, 4'd3, 16'd0, 66, PRESS_NONE);
      run_phase(1'b1, 4'd8, 16'd60, 24, PRESS_NONE);
      run_phase(1'b0, 4'd15, 16'hFFFF, 70, PRESS_DRAIN);
      run_phase(1'b0, 4'd1, 16'd1, 60, PRESS_NONE);
      run_phase(1'b0, 4'd5, 16'd2, 66, PRESS_NONE);
      run_phase(1'b0, 4'd0, 16'd60, 30, PRESS_NONE);
      settle();

      $display("run covered %0d ticks and %0d entry writes under %0d register settings",
               board.ticks, board.writes, settings_applied);
      $display("%0d firings, %0d cooldown skips, %0d reports; %0d results checked, %0d mismatches",
               board.firings, board.skips, board.reports, board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
